[src/mlsu_pkg.sv]
// ----------------------------------------------------------------------------
// mlsu_pkg
// Shared types and constants for the misaligned load/store unit: transfer
// payloads, operation codes, controller states and controller/datapath links.
// ----------------------------------------------------------------------------
package mlsu_pkg;

    localparam int WORD_ADDR_BITS = 14;
    localparam int MEM_DEPTH      = 2 ** WORD_ADDR_BITS;

    localparam logic [31:0] BYTE_MASK = 32'h0000_00FF;
    localparam logic [31:0] HALF_MASK = 32'h0000_FFFF;
    localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFF;

    typedef logic [WORD_ADDR_BITS-1:0] word_idx_t;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_STORE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        SIZE_BYTE    = 2'd0,
        SIZE_HALF    = 2'd1,
        SIZE_WORD    = 2'd2,
        SIZE_INVALID = 2'd3
    } size_t;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_SIZE = 1'b1;

    localparam logic [1:0] OFFSET_LAST = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [1:0]  size;
        logic [31:0] address;
        logic [31:0] write_data;
    } mlsu_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        status;
    } mlsu_out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD1,
        ST_WR0,
        ST_WR1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // capture the request, read the first word
        logic rd_en;       // memory read
        logic wr_en;       // memory write of merged data
        logic sel_second;  // address the second word
        logic clr_en;      // clearing pass write
        logic w0_cap;      // hold the first word
        logic finish;      // load the result register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic spans;       // store touching two words
        logic do_write;    // store with a valid size
        logic clr_last;    // clearing pass on its last word
    } dp_stat_t;

endpackage

[src/mlsu_ctrl.sv]
// ----------------------------------------------------------------------------
// mlsu_ctrl
// Controller state machine: clearing pass after reset, then the read and
// read-modify-write sequence of each load or store.
// ----------------------------------------------------------------------------
module mlsu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mlsu_pkg::dp_stat_t  stat,
    output mlsu_pkg::ctrl_cmd_t cmd
);

    mlsu_pkg::state_t state_reg;
    mlsu_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlsu_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mlsu_pkg::ST_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = mlsu_pkg::ST_IDLE;
                end
            end
            mlsu_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mlsu_pkg::ST_RD1;
                end
            end
            mlsu_pkg::ST_RD1:
            begin
                state_next = mlsu_pkg::ST_WR0;
            end
            mlsu_pkg::ST_WR0:
            begin
                state_next = stat.spans ? mlsu_pkg::ST_WR1 : mlsu_pkg::ST_IDLE;
            end
            mlsu_pkg::ST_WR1:
            begin
                state_next = mlsu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mlsu_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            mlsu_pkg::ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
            end
            mlsu_pkg::ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
                cmd.rd_en  = start;
            end
            mlsu_pkg::ST_RD1:
            begin
                cmd.rd_en      = 1'b1;
                cmd.sel_second = 1'b1;
                cmd.w0_cap     = 1'b1;
            end
            mlsu_pkg::ST_WR0:
            begin
                cmd.wr_en  = stat.do_write;
                cmd.finish = !stat.spans;
            end
            mlsu_pkg::ST_WR1:
            begin
                cmd.wr_en      = 1'b1;
                cmd.sel_second = 1'b1;
                cmd.finish     = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // An accepted request passes through the second-word read state before it reaches the write stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> ##1 (state_reg == mlsu_pkg::ST_WR0))
        else $error("request did not reach the write stage");

    // The second-word write only follows a store that spans two words.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mlsu_pkg::ST_WR1) |-> $past(stat.spans && stat.do_write))
        else $error("second-word write without a spanning store");

    // The controller is ready for a new request right after a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == mlsu_pkg::ST_IDLE))
        else $error("controller not idle after a result");

endmodule

[src/mlsu_dp.sv]
// ----------------------------------------------------------------------------
// mlsu_dp
// Datapath: request register, single-port word memory, byte merge for loads
// and stores, clearing counter and result register.
// ----------------------------------------------------------------------------
module mlsu_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  mlsu_pkg::mlsu_in_t  request,
    input  mlsu_pkg::ctrl_cmd_t cmd,
    output mlsu_pkg::dp_stat_t  stat,
    output logic                done,
    output mlsu_pkg::mlsu_out_t result
);

    logic [31:0] mem [mlsu_pkg::MEM_DEPTH];

    mlsu_pkg::mlsu_in_t  req_reg;
    mlsu_pkg::mlsu_out_t result_reg;
    mlsu_pkg::mlsu_out_t result_next;
    logic                done_reg;
    logic [31:0]         w0_reg;
    logic [31:0]         mem_q;
    mlsu_pkg::word_idx_t clr_cnt_reg;

    mlsu_pkg::word_idx_t i0;
    mlsu_pkg::word_idx_t i1;
    mlsu_pkg::word_idx_t mem_addr;
    logic [31:0]         mem_wdata;
    logic                mem_we;
    logic [1:0]          off;
    logic [4:0]          sh;
    logic [4:0]          hs;
    logic [31:0]         size_mask;
    logic [63:0]         pair;
    logic [63:0]         pair_shr;
    logic [63:0]         mask64;
    logic [63:0]         data64;
    logic [63:0]         merged;
    logic [31:0]         second_word;
    logic [31:0]         load_data;
    logic                is_store;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= request;
        end
        if (cmd.w0_cap)
        begin
            w0_reg <= mem_q;
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.clr_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + mlsu_pkg::word_idx_t'(1);
            end
        end
    end

    assign i0 = req_reg.address[mlsu_pkg::WORD_ADDR_BITS+1:2];
    assign i1 = i0 + mlsu_pkg::word_idx_t'(1);

    always_comb
    begin
        priority if (cmd.clr_en)
        begin
            mem_addr = clr_cnt_reg;
        end
        else if (cmd.accept)
        begin
            mem_addr = request.address[mlsu_pkg::WORD_ADDR_BITS+1:2];
        end
        else if (cmd.sel_second)
        begin
            mem_addr = i1;
        end
        else
        begin
            mem_addr = i0;
        end
    end

    assign mem_we = cmd.clr_en | cmd.wr_en;

    always_comb
    begin
        priority if (cmd.clr_en)
        begin
            mem_wdata = '0;
        end
        else if (cmd.sel_second)
        begin
            mem_wdata = second_word;
        end
        else
        begin
            mem_wdata = merged[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            mem_q <= mem[mem_addr];
        end
    end

    // The two words side by side; the second one is still in the read register.
    assign off  = req_reg.address[1:0];
    assign sh   = {off, 3'b000};
    assign hs   = {2'd0 - off, 3'b000};
    assign pair = {mem_q, w0_reg};

    always_comb
    begin
        unique case (mlsu_pkg::size_t'(req_reg.size))
            mlsu_pkg::SIZE_BYTE:    size_mask = mlsu_pkg::BYTE_MASK;
            mlsu_pkg::SIZE_HALF:    size_mask = mlsu_pkg::HALF_MASK;
            mlsu_pkg::SIZE_WORD:    size_mask = mlsu_pkg::WORD_MASK;
            mlsu_pkg::SIZE_INVALID: size_mask = '0;
            default:                size_mask = '0;
        endcase
    end

    assign pair_shr = pair >> sh;
    assign mask64   = {32'h0, size_mask} << sh;
    assign data64   = {32'h0, req_reg.write_data & size_mask} << sh;
    assign merged   = (pair & ~mask64) | data64;

    // A word store that crosses a boundary keeps the old second word from
    // the complementary shift upward and ORs in the store data shifted down
    // by that same amount.
    assign second_word = (req_reg.size == mlsu_pkg::SIZE_WORD)
                         ? ((mem_q & (mlsu_pkg::WORD_MASK << hs))
                            | (req_reg.write_data >> hs))
                         : merged[63:32];

    // A load with an invalid size returns the aligned word untouched.
    assign load_data = (req_reg.size == mlsu_pkg::SIZE_INVALID) ? w0_reg
                                                                : pair_shr[31:0] & size_mask;

    assign is_store = (req_reg.cmd == mlsu_pkg::CMD_STORE);

    always_comb
    begin
        result_next.read_data = is_store ? 32'h0 : load_data;
        result_next.status    = (is_store && req_reg.size == mlsu_pkg::SIZE_INVALID)
                                ? mlsu_pkg::STATUS_BAD_SIZE : mlsu_pkg::STATUS_OK;
    end

    assign stat.do_write = is_store && (req_reg.size != mlsu_pkg::SIZE_INVALID);
    assign stat.spans    = is_store
                           && (((req_reg.size == mlsu_pkg::SIZE_HALF) && (off == mlsu_pkg::OFFSET_LAST))
                            || ((req_reg.size == mlsu_pkg::SIZE_WORD) && (off != 2'd0)));
    assign stat.clr_last = (clr_cnt_reg == '1);

    assign done   = done_reg;
    assign result = result_reg;

    // A second-word write always comes right after the first-word write.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && cmd.sel_second) |-> $past(cmd.wr_en && !cmd.sel_second))
        else $error("second-word write without first-word write");

    // Loads and stores with an invalid size never write the memory.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (is_store && req_reg.size != mlsu_pkg::SIZE_INVALID))
        else $error("memory write from a load or an invalid store");

    // Each transfer gives one result strobe, never two in a row.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

endmodule

[src/misaligned_load_store_unit_top.sv]
// ----------------------------------------------------------------------------
// misaligned_load_store_unit_top
// Little-endian word memory with one load/store port for bytes, halves and
// words at any byte address; accesses that cross a word boundary touch two
// consecutive words.
//
//   Channel   Handshake          Payload              Direction
//   request   start / busy       request (mlsu_in_t)  in
//   result    done (one cycle)   result (mlsu_out_t)  out
//
// The single memory port sets the spacing of accepted transfers: two reads,
// then one write slot per word touched (a load or an invalid-size store
// passes through one slot without writing), so a store crossing a word
// boundary keeps the unit busy one slot longer than other transfers.
// After reset, busy stays high while all 16384 words of the memory are cleared.
// The result strobe comes in the cycle after the last write slot and can
// overlap the next accepted request. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module misaligned_load_store_unit_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mlsu_pkg::mlsu_in_t  request,
    output logic                done,
    output mlsu_pkg::mlsu_out_t result
);

    mlsu_pkg::ctrl_cmd_t cmd;
    mlsu_pkg::dp_stat_t  stat;

    mlsu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    mlsu_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule
